[design/cht_pkg.sv]
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and codes of the chained hash table.
// ----------------------------------------------------------------------------
`default_nettype none
package cht_pkg;
    // bucket count, a power of two: the low key bits pick the bucket
    localparam int BUCKETS = 16;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_SEARCH = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load;       // capture input item
        logic alloc;      // pop free node, write node, link at head
        logic walk_rd;    // issue read of current node
        logic step;       // advance to next node
        logic unlink;     // unlink current node and free it
        logic res_load;   // register result
        logic [1:0] res_status;
        logic res_pay;    // take payload of current node
    } cht_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] cmd;
        logic pool_empty;
        logic cur_nil;    // current link is null or walk bound reached
        logic key_hit;    // node read data key matches
    } cht_stat_t;
endpackage
`default_nettype wire

[design/cht_ram.sv]
// ----------------------------------------------------------------------------
// cht_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module cht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     aclk,
    input  wire                     we,
    input  wire [$clog2(DEPTH)-1:0] waddr,
    input  wire [WIDTH-1:0]         wdata,
    input  wire [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[design/cht_datapath.sv]
// ----------------------------------------------------------------------------
// cht_datapath
// Bucket heads, node store, free stack and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module cht_datapath #(
    parameter int NODES        = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire [1:0]                in_cmd,
    input  wire [31:0]               in_key,
    input  wire [31:0]               in_payload,
    input  wire cht_pkg::cht_cmd_t   ctl,
    output cht_pkg::cht_stat_t       stat,
    output logic [1:0]               res_status,
    output logic [31:0]              res_payload,
    output logic [3:0]               res_bucket,
    output logic                     clear_busy
);
    localparam int NW = $clog2(NODES);
    localparam int BW = $clog2(cht_pkg::BUCKETS);
    localparam int LW = NW + 1;                 // link width, NODES is null
    localparam logic [LW-1:0] NIL = LW'(NODES);
    localparam int SW = $clog2(NODES + 1);      // walk step counter

    // bucket heads: small register file, valid bits give the empty reset
    logic [LW-1:0] head_reg [cht_pkg::BUCKETS];
    logic [cht_pkg::BUCKETS-1:0] head_vld_reg;

    logic [1:0]        cmd_reg;
    logic [31:0]       key_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [BW-1:0]     bkt_reg;
    logic [LW-1:0]     cur_reg, prev_reg;
    logic [SW-1:0]     steps_reg;
    logic [LW-1:0]     fcnt_reg;
    logic [NW:0]       clr_reg;   // free stack initialisation sweep

    // key modulo the bucket count: its low bits
    logic [BW-1:0] in_bkt;
    assign in_bkt = in_key[BW-1:0];

    logic [LW-1:0] head_cur;
    assign head_cur = head_vld_reg[bkt_reg] ? head_reg[bkt_reg] : NIL;

    // node store: key and payload and next in separate RAMs
    logic          node_we;
    logic [NW-1:0] node_waddr, node_raddr;
    logic [31:0]   rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;
    logic [LW-1:0] rd_next, next_wdata;
    logic          next_we;
    logic [NW-1:0] next_waddr;

    // free stack
    logic          fs_we;
    logic [NW-1:0] fs_waddr, fs_raddr, fs_wdata, fs_rdata;

    assign clear_busy = (clr_reg != (NW+1)'(NODES));
    assign fs_raddr   = NW'(fcnt_reg - LW'(1));
    assign node_raddr = cur_reg[NW-1:0];
    assign node_waddr = fs_rdata;
    assign node_we    = ctl.alloc;

    always_comb begin
        fs_we = 1'b0; fs_waddr = '0; fs_wdata = '0;
        if (clear_busy) begin
            fs_we = 1'b1; fs_waddr = clr_reg[NW-1:0]; fs_wdata = clr_reg[NW-1:0];
        end else if (ctl.unlink) begin
            fs_we = 1'b1; fs_waddr = fcnt_reg[NW-1:0]; fs_wdata = cur_reg[NW-1:0];
        end
        next_we = 1'b0; next_waddr = fs_rdata; next_wdata = head_cur;
        if (ctl.alloc) begin
            next_we = 1'b1;
        end else if (ctl.unlink && prev_reg != NIL) begin
            next_we = 1'b1; next_waddr = prev_reg[NW-1:0]; next_wdata = rd_next;
        end
    end

    cht_ram #(.WIDTH(32), .DEPTH(NODES)) u_key (
        .aclk(aclk), .we(node_we), .waddr(node_waddr), .wdata(key_reg),
        .raddr(node_raddr), .rdata(rd_key));
    cht_ram #(.WIDTH(PAYLOAD_BITS), .DEPTH(NODES)) u_pay (
        .aclk(aclk), .we(node_we), .waddr(node_waddr), .wdata(pay_reg),
        .raddr(node_raddr), .rdata(rd_pay));
    cht_ram #(.WIDTH(LW), .DEPTH(NODES)) u_next (
        .aclk(aclk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .raddr(node_raddr), .rdata(rd_next));
    cht_ram #(.WIDTH(NW), .DEPTH(NODES)) u_free (
        .aclk(aclk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
        .raddr(fs_raddr), .rdata(fs_rdata));

    assign stat = '{cmd:        cmd_reg,
                    pool_empty: (fcnt_reg == '0),
                    cur_nil:    (cur_reg >= NIL) || (steps_reg >= SW'(NODES)),
                    key_hit:    (rd_key == key_reg)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_vld_reg <= '0;
            fcnt_reg     <= LW'(NODES);
            clr_reg      <= '0;
        end else begin
            if (clear_busy) begin
                clr_reg <= clr_reg + (NW+1)'(1);
            end
            if (ctl.alloc) begin
                head_reg[bkt_reg]     <= {1'b0, fs_rdata};
                head_vld_reg[bkt_reg] <= 1'b1;
                fcnt_reg              <= fcnt_reg - LW'(1);
            end
            if (ctl.unlink) begin
                if (prev_reg == NIL) begin
                    head_reg[bkt_reg]     <= rd_next;
                    head_vld_reg[bkt_reg] <= 1'b1;
                end
                fcnt_reg <= fcnt_reg + LW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg <= in_cmd;
            key_reg <= in_key;
            pay_reg <= PAYLOAD_BITS'(in_payload);
            bkt_reg <= in_bkt;
        end
        if (ctl.walk_rd) begin
            cur_reg   <= head_cur;
            prev_reg  <= NIL;
            steps_reg <= '0;
        end
        if (ctl.step) begin
            prev_reg  <= cur_reg;
            cur_reg   <= rd_next;
            steps_reg <= steps_reg + SW'(1);
        end
        if (ctl.res_load) begin
            res_status  <= ctl.res_status;
            res_payload <= ctl.res_pay ? 32'(rd_pay) : 32'd0;
            res_bucket  <= 4'(bkt_reg);
        end
    end
endmodule
`default_nettype wire

[design/cht_ctrl.sv]
// ----------------------------------------------------------------------------
// cht_ctrl
// Controller sequencing one operation at a time and the output handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module cht_ctrl (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire                      out_ready,
    input  wire                      clear_busy,
    input  wire cht_pkg::cht_stat_t  stat,
    output cht_pkg::cht_cmd_t        ctl
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_ALLOC = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_TEST  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;

    // result register may still be full while a new item is taken
    assign in_ready  = (state_reg == S_IDLE) && !clear_busy;
    assign out_valid = ov_reg;

    always_comb begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid && in_ready) begin
                    ctl.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                priority if (stat.cmd == cht_pkg::CMD_INSERT) begin
                    state_next = S_ALLOC; // free stack read in flight
                end else if (stat.cmd == cht_pkg::CMD_SEARCH ||
                             stat.cmd == cht_pkg::CMD_REMOVE) begin
                    ctl.walk_rd = 1'b1;
                    state_next  = S_CHECK;
                end else begin
                    ctl.res_status = cht_pkg::ST_NOTFOUND;
                    state_next     = S_OUT;
                end
            end
            S_ALLOC: begin
                if (stat.pool_empty) begin
                    ctl.res_status = cht_pkg::ST_FULL;
                end else begin
                    ctl.alloc      = 1'b1;
                    ctl.res_status = cht_pkg::ST_DONE;
                end
                state_next = S_OUT;
            end
            S_CHECK: begin
                if (stat.cur_nil) begin
                    ctl.res_status = cht_pkg::ST_NOTFOUND;
                    state_next     = S_OUT;
                end else begin
                    state_next = S_WAIT; // node read in flight
                end
            end
            S_WAIT: state_next = S_TEST;
            S_TEST: begin
                if (stat.key_hit) begin
                    ctl.res_status = cht_pkg::ST_DONE;
                    if (stat.cmd == cht_pkg::CMD_SEARCH) begin
                        ctl.res_pay = 1'b1;
                    end else begin
                        ctl.unlink = 1'b1;
                    end
                    state_next = S_OUT;
                end else begin
                    ctl.step   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_OUT: begin
                if (!ov_reg || out_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_OUT && (!ov_reg || out_ready)) begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end
endmodule
`default_nettype wire

[design/cht_result.sv]
// ----------------------------------------------------------------------------
// cht_result
// Holds the outcome of the running operation until the output slot frees.
// ----------------------------------------------------------------------------
`default_nettype none
module cht_result (
    input  wire        aclk,
    input  wire        capture,
    input  wire [1:0]  status_in,
    input  wire        use_pay,
    input  wire        publish,
    input  wire [1:0]  dp_status,
    output logic [1:0] pend_status,
    output logic       pend_pay
);
    logic [1:0] st_reg;
    logic       pay_reg;

    always_ff @(posedge aclk) begin
        if (capture) begin
            st_reg  <= status_in;
            pay_reg <= use_pay;
        end
    end
    assign pend_status = publish ? st_reg : dp_status;
    assign pend_pay    = publish & pay_reg;
endmodule
`default_nettype wire

[design/chained_hash_table.sv]
// ----------------------------------------------------------------------------
// chained_hash_table
// Key-to-payload map with separate chaining and a bounded node pool.
// ----------------------------------------------------------------------------
// One item (insert, search or remove) is handled at a time; the bucket count
// is fixed at 16 and the bucket is the low four key bits. An insert goes from
// dispatch through allocate to the output state. A search or remove visits
// each node through address, registered read and compare steps until a hit,
// a null link or the walk bound ends it. The controller returns to idle once
// the output register is free. The finished result sits in an output
// register, so the next item is taken while it waits. After reset the
// free-node stack is initialised by a sweep over all NODES entries, during
// which no item is accepted.
`default_nettype none
module chained_hash_table #(
    parameter int NODES        = 64,
    parameter int PAYLOAD_BITS = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [71:0] s_tdata,   // cmd[1:0], key[33:2], payload_in[65:34], zero
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata    // status[1:0], payload_out[33:2], bucket[37:34]
);
    cht_pkg::cht_cmd_t  ctl, ctl_c;
    cht_pkg::cht_stat_t stat;
    logic [1:0]  res_status, pend_status;
    logic [31:0] res_payload;
    logic [3:0]  res_bucket;
    logic        clear_busy, pend_pay, publish, capture;
    logic        m_tvalid_next_load;
    logic        out_state_reg;

    cht_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .clear_busy(clear_busy),
        .stat(stat), .ctl(ctl_c));

    // outcome captured when decided, published into the result register on
    // leaving the output wait state
    assign capture = ctl_c.res_status != cht_pkg::ST_DONE || ctl_c.alloc
                   || ctl_c.unlink || ctl_c.res_pay;
    assign publish = !ctl_c.load && !capture && m_tvalid_next_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_state_reg <= 1'b0;
        end else begin
            out_state_reg <= capture || (out_state_reg && !(~m_tvalid || m_tready));
        end
    end
    assign m_tvalid_next_load = out_state_reg && (!m_tvalid || m_tready);

    cht_result u_res (
        .aclk(aclk), .capture(capture), .status_in(ctl_c.res_status),
        .use_pay(ctl_c.res_pay), .publish(publish), .dp_status(ctl_c.res_status),
        .pend_status(pend_status), .pend_pay(pend_pay));

    // payload of a search hit is taken from RAM read data, which holds until
    // the next read; the walk does not advance while the result waits
    always_comb begin
        ctl            = ctl_c;
        ctl.res_load   = publish;
        ctl.res_status = pend_status;
        ctl.res_pay    = pend_pay;
    end

    cht_datapath #(.NODES(NODES), .PAYLOAD_BITS(PAYLOAD_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .in_cmd(s_tdata[1:0]), .in_key(s_tdata[33:2]), .in_payload(s_tdata[65:34]),
        .ctl(ctl), .stat(stat), .res_status(res_status), .res_payload(res_payload),
        .res_bucket(res_bucket), .clear_busy(clear_busy));

    assign m_tdata = {2'b00, res_bucket, res_payload, res_status};

    // no item taken during the free stack sweep
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !s_tready) else $error("item taken during clear");
    // an alloc and an unlink never coincide
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctl.alloc && ctl.unlink)) else $error("alloc and unlink together");
    // no new item while an operation is running
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.load |=> !s_tready) else $error("overlapping items");
endmodule
`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the chained hash table against its own predictor of the chains, the
// node pool and the free stack. Directed items cover the edges and the pool
// full case; random phases then mix inserts, searches and removes on small
// key sets, with random gaps on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
    localparam int NBUCKET = cht_pkg::BUCKETS;
    localparam int NPOOL   = 64;
    localparam int NIL     = NPOOL;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] payload;
        logic [3:0]  bucket;
    } answer_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;

    chained_hash_table uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #10 aclk = ~aclk;

    // predictor state
    int          head_of[NBUCKET];
    logic [31:0] key_of[NPOOL];
    logic [31:0] pay_of[NPOOL];
    int          next_of[NPOOL];
    int          free_stack[NPOOL];
    int          free_left;

    answer_t     pending_answers[$];
    int          mismatches = 0;
    longint      cycles = 0;
    int          hold_cycles = 0;   // receiver hold-off left, owned by the receiver
    int          hold_request = 0;  // bumped by a test to ask for a long hold-off
    int          hold_seen = 0;
    logic [31:0] live_keys[$];      // keys most likely present

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // receiver: short random stalls, a few long ones, a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_request != hold_seen) begin
            hold_seen   <= hold_request;
            hold_cycles <= 200;
            m_tready    <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready    <= 1'b0;
        end else if ($urandom_range(0, 199) == 0) begin
            hold_cycles <= $urandom_range(10, 40);
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 9) < 7);
        end
    end

    // result checker
    always @(posedge aclk) begin
        answer_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status  = m_tdata[1:0];
            got.payload = m_tdata[33:2];
            got.bucket  = m_tdata[37:34];
            if (pending_answers.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", m_tdata);
            end else begin
                want = pending_answers.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp st=%0d pay=%h bkt=%0d, got st=%0d pay=%h bkt=%0d",
                                 want.status, want.payload, want.bucket,
                                 got.status, got.payload, got.bucket);
                end
            end
        end
    end

    task automatic clear_table();
        for (int i = 0; i < NBUCKET; i++) head_of[i] = NIL;
        for (int i = 0; i < NPOOL; i++) begin
            key_of[i] = '0; pay_of[i] = '0; next_of[i] = 0; free_stack[i] = i;
        end
        free_left = NPOOL;
    endtask

    // newest node holding the key; prev is NIL at the head
    function automatic int find_newest(int b, logic [31:0] k, output int prev);
        int p, n, steps;
        p = NIL; n = head_of[b]; steps = 0;
        prev = NIL;
        while (n < NPOOL && steps < NPOOL) begin
            if (key_of[n] == k) begin
                prev = p;
                return n;
            end
            p = n; n = next_of[n]; steps++;
        end
        return NIL;
    endfunction

    function automatic answer_t table_op(logic [1:0] op, logic [31:0] k,
                                         logic [31:0] pay);
        answer_t a;
        int b, n, prev;
        b = k % NBUCKET;
        a.status = cht_pkg::ST_NOTFOUND; a.payload = '0; a.bucket = b[3:0];
        case (op)
            cht_pkg::CMD_INSERT: begin
                if (free_left == 0)
                    a.status = cht_pkg::ST_FULL;
                else begin
                    free_left--;
                    n = free_stack[free_left];
                    key_of[n] = k; pay_of[n] = pay;
                    next_of[n] = head_of[b]; head_of[b] = n;
                    a.status = cht_pkg::ST_DONE;
                end
            end
            cht_pkg::CMD_SEARCH: begin
                n = find_newest(b, k, prev);
                if (n < NPOOL) begin
                    a.status = cht_pkg::ST_DONE; a.payload = pay_of[n];
                end
            end
            cht_pkg::CMD_REMOVE: begin
                n = find_newest(b, k, prev);
                if (n < NPOOL) begin
                    if (prev < NPOOL) next_of[prev] = next_of[n];
                    else head_of[b] = next_of[n];
                    if (free_left < NPOOL) begin
                        free_stack[free_left] = n; free_left++;
                    end
                    a.status = cht_pkg::ST_DONE;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    // sends one item, with a random gap first
    task automatic send_item(logic [1:0] op, logic [31:0] k, logic [31:0] pay);
        int gap;
        gap = ($urandom_range(0, 9) < 6) ? 0 :
              ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 30);
        if (hold_cycles > 0) gap = 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, pay, k, op};
        do @(posedge aclk); while (!s_tready);
        pending_answers.push_back(table_op(op, k, pay));
        if (op == cht_pkg::CMD_INSERT) live_keys.push_back(k);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_key(int pool_sz);
        if (live_keys.size() != 0 && $urandom_range(0, 3) != 0)
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        if ($urandom_range(0, 3) == 0) return $urandom;
        return $urandom_range(0, pool_sz);
    endfunction

    task automatic test_edges();
        send_item(cht_pkg::CMD_SEARCH, 32'h0, 32'h0);           // miss on empty table
        send_item(cht_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);   // remove miss
        send_item(cht_pkg::CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(cht_pkg::CMD_INSERT, 32'h0, 32'h0);
        send_item(cht_pkg::CMD_INSERT, 32'h10, 32'hA5A5_5A5A);  // same bucket as 0
        send_item(cht_pkg::CMD_INSERT, 32'h0, 32'h1234_5678);   // duplicate key
        send_item(cht_pkg::CMD_SEARCH, 32'h0, 32'h0);           // newest duplicate
        send_item(cht_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 32'h0);
        send_item(cht_pkg::CMD_SEARCH, 32'h20, 32'h0);          // same bucket, miss
        send_item(cht_pkg::CMD_REMOVE, 32'h10, 32'h0);          // mid-chain unlink
        send_item(cht_pkg::CMD_REMOVE, 32'h0, 32'h0);
        send_item(cht_pkg::CMD_SEARCH, 32'h0, 32'h0);           // older duplicate
        send_item(cht_pkg::CMD_SEARCH, 32'h10, 32'h0);
        send_item(2'd3, 32'h5555_AAAA, 32'hAAAA_5555);          // unused command
        send_item(cht_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 32'h0);
        drain();
    endtask

    // fills the pool, overflows it, then empties it again
    task automatic test_pool_full();
        for (int i = 0; i < NPOOL + 3; i++)
            send_item(cht_pkg::CMD_INSERT, i * 7, $urandom);
        send_item(cht_pkg::CMD_SEARCH, 32'd7, 32'h0);
        for (int i = 0; i < NPOOL + 2; i++)
            send_item(cht_pkg::CMD_REMOVE, i * 7, 32'h0);
        live_keys.delete();
        drain();
    endtask

    // output held off while the sender keeps offering items
    task automatic test_backpressure();
        @(posedge aclk);
        hold_request++;
        for (int i = 0; i < 20; i++)
            send_item(cht_pkg::CMD_INSERT, $urandom_range(0, 40), $urandom);
        drain();
    endtask

    task automatic test_random(int count, int key_span);
        logic [1:0] op;
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            op = (r < 40) ? cht_pkg::CMD_INSERT : (r < 70) ? cht_pkg::CMD_SEARCH :
                 (r < 98) ? cht_pkg::CMD_REMOVE : 2'd3;
            send_item(op, pick_key(key_span), $urandom);
            if (live_keys.size() > 200) live_keys.delete();
        end
        drain();
    endtask

    initial begin
        clear_table();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_edges();
        test_pool_full();
        test_backpressure();
        test_random(600, 40);
        test_random(500, 200);
        test_random(450, 15);
        repeat (300) @(posedge aclk);
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
`default_nettype wire

[filelist.f]
design/cht_pkg.sv
design/cht_ram.sv
design/cht_datapath.sv
design/cht_ctrl.sv
design/cht_result.sv
design/chained_hash_table.sv
verif/testbench.sv
